/* src/lcfb_pkg.sv */
// Package for the lamp command frame builder: types, codes and the microcode table.
package lcfb_pkg;

    // Widths of the stream payloads.
    localparam int unsigned ByteW     = 8;
    localparam int unsigned ModeW     = 3;
    localparam int unsigned InDataW   = 48;
    localparam int unsigned PcW       = 6;

    // Checksum starts from this bias.
    localparam logic [ByteW-1:0] CsumBias = 8'd85;

    // Command codes carried in the input tuser.
    localparam logic [ModeW-1:0] MODE_ON     = 3'd0;
    localparam logic [ModeW-1:0] MODE_OFF    = 3'd1;
    localparam logic [ModeW-1:0] MODE_BRIGHT = 3'd2;
    localparam logic [ModeW-1:0] MODE_WHITE  = 3'd3;
    localparam logic [ModeW-1:0] MODE_COLOUR = 3'd4;

    // Entry points of the program. The shared header runs first, then
    // dispatches to the tail of the command.
    localparam logic [PcW-1:0] PC_HEADER = 6'd0;
    localparam logic [PcW-1:0] PC_ON     = 6'd6;
    localparam logic [PcW-1:0] PC_OFF    = 6'd12;
    localparam logic [PcW-1:0] PC_BRIGHT = 6'd18;
    localparam logic [PcW-1:0] PC_WHITE  = 6'd24;
    localparam logic [PcW-1:0] PC_COLOUR = 6'd30;

    // Sequencer state.
    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_seq_state;

    // Where a step takes its output byte from.
    typedef enum logic [2:0] {
        SRC_CONST,
        SRC_LEVEL,
        SRC_NONCE,
        SRC_RED,
        SRC_GREEN,
        SRC_BLUE,
        SRC_FLAG,
        SRC_SUM
    } t_src;

    // One control word of the program.
    typedef struct packed {
        t_src             src;
        logic [ByteW-1:0] konst;
        logic             sum_en;
        logic             last;
        logic             dispatch;
    } t_ctrl;

    // Build a control word.
    function automatic t_ctrl mk(input t_src src, input logic [ByteW-1:0] konst,
                                 input logic sum_en, input logic last,
                                 input logic dispatch);
        t_ctrl w;
        w.src      = src;
        w.konst    = konst;
        w.sum_en   = sum_en;
        w.last     = last;
        w.dispatch = dispatch;
        return w;
    endfunction

    // Microcode table.
    function automatic t_ctrl ucode(input logic [PcW-1:0] pc);
        t_ctrl w;
        w = mk(SRC_CONST, 8'h0D, 1'b0, 1'b1, 1'b0);
        unique case (pc)
            // Shared header, byte 0 is outside the checksum.
            6'd0:  w = mk(SRC_CONST, 8'hAA, 1'b0, 1'b0, 1'b0);
            6'd1:  w = mk(SRC_CONST, 8'h0A, 1'b1, 1'b0, 1'b0);
            6'd2:  w = mk(SRC_CONST, 8'hFC, 1'b1, 1'b0, 1'b0);
            6'd3:  w = mk(SRC_CONST, 8'h3A, 1'b1, 1'b0, 1'b0);
            6'd4:  w = mk(SRC_CONST, 8'h86, 1'b1, 1'b0, 1'b0);
            6'd5:  w = mk(SRC_CONST, 8'h01, 1'b1, 1'b0, 1'b1);
            // On.
            6'd6:  w = mk(SRC_CONST, 8'h0A, 1'b0, 1'b0, 1'b0);
            6'd7:  w = mk(SRC_CONST, 8'h01, 1'b0, 1'b0, 1'b0);
            6'd8:  w = mk(SRC_CONST, 8'h01, 1'b0, 1'b0, 1'b0);
            6'd9:  w = mk(SRC_CONST, 8'h00, 1'b0, 1'b0, 1'b0);
            6'd10: w = mk(SRC_CONST, 8'h28, 1'b0, 1'b0, 1'b0);
            6'd11: w = mk(SRC_CONST, 8'h0D, 1'b0, 1'b1, 1'b0);
            // Off.
            6'd12: w = mk(SRC_CONST, 8'h0A, 1'b0, 1'b0, 1'b0);
            6'd13: w = mk(SRC_CONST, 8'h01, 1'b0, 1'b0, 1'b0);
            6'd14: w = mk(SRC_CONST, 8'h00, 1'b0, 1'b0, 1'b0);
            6'd15: w = mk(SRC_CONST, 8'h01, 1'b0, 1'b0, 1'b0);
            6'd16: w = mk(SRC_CONST, 8'h28, 1'b0, 1'b0, 1'b0);
            6'd17: w = mk(SRC_CONST, 8'h0D, 1'b0, 1'b1, 1'b0);
            // Brightness.
            6'd18: w = mk(SRC_CONST, 8'h0C, 1'b1, 1'b0, 1'b0);
            6'd19: w = mk(SRC_CONST, 8'h01, 1'b1, 1'b0, 1'b0);
            6'd20: w = mk(SRC_LEVEL, 8'h00, 1'b1, 1'b0, 1'b0);
            6'd21: w = mk(SRC_NONCE, 8'h00, 1'b1, 1'b0, 1'b0);
            6'd22: w = mk(SRC_SUM,   8'h00, 1'b0, 1'b0, 1'b0);
            6'd23: w = mk(SRC_CONST, 8'h0D, 1'b0, 1'b1, 1'b0);
            // White temperature.
            6'd24: w = mk(SRC_CONST, 8'h0E, 1'b1, 1'b0, 1'b0);
            6'd25: w = mk(SRC_CONST, 8'h01, 1'b1, 1'b0, 1'b0);
            6'd26: w = mk(SRC_LEVEL, 8'h00, 1'b1, 1'b0, 1'b0);
            6'd27: w = mk(SRC_NONCE, 8'h00, 1'b1, 1'b0, 1'b0);
            6'd28: w = mk(SRC_SUM,   8'h00, 1'b0, 1'b0, 1'b0);
            6'd29: w = mk(SRC_CONST, 8'h0D, 1'b0, 1'b1, 1'b0);
            // Colour.
            6'd30: w = mk(SRC_CONST, 8'h0D, 1'b1, 1'b0, 1'b0);
            6'd31: w = mk(SRC_CONST, 8'h06, 1'b1, 1'b0, 1'b0);
            6'd32: w = mk(SRC_FLAG,  8'h00, 1'b1, 1'b0, 1'b0);
            6'd33: w = mk(SRC_RED,   8'h00, 1'b1, 1'b0, 1'b0);
            6'd34: w = mk(SRC_GREEN, 8'h00, 1'b1, 1'b0, 1'b0);
            6'd35: w = mk(SRC_BLUE,  8'h00, 1'b1, 1'b0, 1'b0);
            6'd36: w = mk(SRC_CONST, 8'h20, 1'b1, 1'b0, 1'b0);
            6'd37: w = mk(SRC_CONST, 8'h30, 1'b1, 1'b0, 1'b0);
            6'd38: w = mk(SRC_NONCE, 8'h00, 1'b1, 1'b0, 1'b0);
            6'd39: w = mk(SRC_SUM,   8'h00, 1'b0, 1'b0, 1'b0);
            6'd40: w = mk(SRC_CONST, 8'h0D, 1'b0, 1'b1, 1'b0);
            // Unused addresses end the frame.
            default: w = mk(SRC_CONST, 8'h0D, 1'b0, 1'b1, 1'b0);
        endcase
        return w;
    endfunction

    // Dispatch target after the header, per command.
    function automatic logic [PcW-1:0] tail_entry(input logic [ModeW-1:0] mode);
        logic [PcW-1:0] pc;
        pc = PC_COLOUR;
        unique case (mode)
            MODE_ON:     pc = PC_ON;
            MODE_OFF:    pc = PC_OFF;
            MODE_BRIGHT: pc = PC_BRIGHT;
            MODE_WHITE:  pc = PC_WHITE;
            default:     pc = PC_COLOUR;
        endcase
        return pc;
    endfunction

endpackage

/* src/lamp_command_frame_builder.sv */
// Top level of the lamp command frame builder: a microcoded byte sequencer.
//
//  Channel   Direction  Payload                                          Handshake
//  s_axis    in         tuser: mode; tdata: level, red, green, blue,     tvalid/tready
//                       special, nonce
//  m_axis    out        tdata: frame_byte; tlast: last                   tvalid/tready
//
// The first byte reaches the output register after the sequencer enters its run state, and one
// byte follows per cycle while m_axis does not stall. No new command is taken until the last
// byte of the frame is issued; the program counter steps once per byte, so frame length sets
// the rate. Undefined commands are taken and dropped without a frame.
// Reset is synchronous and clears the sequencer state and the output valid flag.
// A stall on m_axis holds the output register and freezes the program counter.
module lamp_command_frame_builder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [lcfb_pkg::InDataW-1:0] s_axis_tdata,  // level[7:0], red[15:8],
                                        // green[23:16], blue[31:24], special[32],
                                        // nonce[40:33]
    input  logic [2:0]  s_axis_tuser,   // mode[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // frame_byte[7:0]
    output logic        m_axis_tlast
);

    lcfb_pkg::t_seq_state r_state, n_state;
    logic [lcfb_pkg::PcW-1:0]   r_pc, n_pc;
    logic [lcfb_pkg::ByteW-1:0] r_sum, n_sum;
    logic [lcfb_pkg::ModeW-1:0] r_mode, n_mode;
    logic [lcfb_pkg::ByteW-1:0] r_level, n_level;
    logic [lcfb_pkg::ByteW-1:0] r_red, n_red;
    logic [lcfb_pkg::ByteW-1:0] r_green, n_green;
    logic [lcfb_pkg::ByteW-1:0] r_blue, n_blue;
    logic                       r_special, n_special;
    logic [lcfb_pkg::ByteW-1:0] r_nonce, n_nonce;
    logic                       r_out_valid, n_out_valid;
    logic [lcfb_pkg::ByteW-1:0] r_out_byte, n_out_byte;
    logic                       r_out_last, n_out_last;

    lcfb_pkg::t_ctrl            ctrl;
    logic [lcfb_pkg::ByteW-1:0] step_byte;
    logic                       in_xfer;
    logic                       step_go;

    // Control word of the current step.
    assign ctrl = lcfb_pkg::ucode(r_pc);

    // Datapath byte select.
    always_comb begin
        unique case (ctrl.src)
            lcfb_pkg::SRC_CONST: step_byte = ctrl.konst;
            lcfb_pkg::SRC_LEVEL: step_byte = r_level;
            lcfb_pkg::SRC_NONCE: step_byte = r_nonce;
            lcfb_pkg::SRC_RED:   step_byte = r_red;
            lcfb_pkg::SRC_GREEN: step_byte = r_green;
            lcfb_pkg::SRC_BLUE:  step_byte = r_blue;
            lcfb_pkg::SRC_FLAG:  step_byte = r_special ? 8'h02 : 8'h01;
            lcfb_pkg::SRC_SUM:   step_byte = r_sum;
            default:             step_byte = ctrl.konst;
        endcase
    end

    assign s_axis_tready = (r_state == lcfb_pkg::ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign step_go       = (r_state == lcfb_pkg::ST_RUN) && (!r_out_valid || m_axis_tready);

    // Sequencer next state, command capture and output register.
    always_comb begin
        n_state     = r_state;
        n_pc        = r_pc;
        n_sum       = r_sum;
        n_mode      = r_mode;
        n_level     = r_level;
        n_red       = r_red;
        n_green     = r_green;
        n_blue      = r_blue;
        n_special   = r_special;
        n_nonce     = r_nonce;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;

        // The output register empties when its transfer completes.
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            lcfb_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    n_mode    = s_axis_tuser;
                    n_level   = s_axis_tdata[7:0];
                    n_red     = s_axis_tdata[15:8];
                    n_green   = s_axis_tdata[23:16];
                    n_blue    = s_axis_tdata[31:24];
                    n_special = s_axis_tdata[32];
                    n_nonce   = s_axis_tdata[40:33];
                    n_pc      = lcfb_pkg::PC_HEADER;
                    n_sum     = lcfb_pkg::CsumBias;
                    // Undefined commands produce no frame.
                    if (s_axis_tuser <= lcfb_pkg::MODE_COLOUR) begin
                        n_state = lcfb_pkg::ST_RUN;
                    end
                end
            end
            lcfb_pkg::ST_RUN: begin
                if (step_go) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = step_byte;
                    n_out_last  = ctrl.last;
                    if (ctrl.sum_en) begin
                        n_sum = r_sum + step_byte;
                    end
                    priority if (ctrl.last) begin
                        n_state = lcfb_pkg::ST_IDLE;
                    end else if (ctrl.dispatch) begin
                        n_pc = lcfb_pkg::tail_entry(r_mode);
                    end else begin
                        n_pc = r_pc + 1'b1;
                    end
                end
            end
            default: n_state = lcfb_pkg::ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lcfb_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_pc       <= n_pc;
        r_sum      <= n_sum;
        r_mode     <= n_mode;
        r_level    <= n_level;
        r_red      <= n_red;
        r_green    <= n_green;
        r_blue     <= n_blue;
        r_special  <= n_special;
        r_nonce    <= n_nonce;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tlast  = r_out_last;

endmodule
